// File: rtl/core/bur_pkg.sv
// ---------------------------------------------------------------------------
// bur_pkg
// Shared types and constants for the buffered UART ring front end.
// ---------------------------------------------------------------------------
package bur_pkg;

   localparam int RxDepthDefault = 64;
   localparam int TxDepthDefault = 64;

   localparam int CsrIndexWidth = 2;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_NL = 8'h0A;

   typedef enum logic [2:0] {
      REQ_RX_BYTE    = 3'd0,
      REQ_TX_READY   = 3'd1,
      REQ_HOST_WRITE = 3'd2,
      REQ_HOST_READ  = 3'd3,
      REQ_TX_DISCARD = 3'd4
   } req_kind_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_TX_NL_TO_CR = 2'd0,
      CSR_RX_CR_TO_NL = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic tx_nl_to_cr;
      logic rx_cr_to_nl;
   } cfg_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic flush;
   } ring_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } ring_stat_type;

   // what the second stage must do once the ring read data is back
   typedef struct packed {
      logic rd_rx;
      logic rd_tx;
      logic acc;
   } pend_type;

endpackage

// File: rtl/core/bur_ring.sv
// ---------------------------------------------------------------------------
// bur_ring
// Byte ring on a single-port-per-direction synchronous memory. One slot
// always stays empty; pointers pre-advance before each access.
// ---------------------------------------------------------------------------
module bur_ring
   import bur_pkg::*;
#(
   parameter int DEPTH = RxDepthDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ring_cmd_type               cmd,
   input  logic [7:0]                 wdata,
   output logic [7:0]                 rdata,
   output ring_stat_type              stat,
   output logic [$clog2(DEPTH)-1:0]   count
);

   localparam int PW = $clog2(DEPTH);

   logic [7:0]    store_ff [DEPTH];
   logic [7:0]    rdata_ff;
   logic [PW-1:0] wptr_ff, wptr_in;
   logic [PW-1:0] rptr_ff, rptr_in;
   logic [PW-1:0] wnext;
   logic [PW-1:0] rnext;
   logic [PW:0]   diff;

   assign wnext = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
   assign rnext = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      if (cmd.push) begin
         wptr_in = wnext;
      end
      if (cmd.pop) begin
         rptr_in = rnext;
      end else if (cmd.flush) begin
         rptr_in = wptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         store_ff[wnext] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         rdata_ff <= store_ff[rnext];
      end
   end

   // fill level, wrapping by DEPTH rather than by the pointer width
   always_comb begin
      if (wptr_ff >= rptr_ff) begin
         diff = {1'b0, wptr_ff} - {1'b0, rptr_ff};
      end else begin
         diff = {1'b0, wptr_ff} + (PW + 1)'(DEPTH) - {1'b0, rptr_ff};
      end
   end

   assign count      = diff[PW-1:0];
   assign rdata      = rdata_ff;
   assign stat.empty = (wptr_ff == rptr_ff);
   assign stat.full  = (wnext == rptr_ff);

endmodule

// File: rtl/core/bur_ctrl.sv
// ---------------------------------------------------------------------------
// bur_ctrl
// Request decode: drives the ring commands, keeps the error flags and the
// transmit service flag, and tells the read stage what to return.
// ---------------------------------------------------------------------------
module bur_ctrl
   import bur_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [2:0]    req_type,
   input  logic [7:0]    req_data_in,
   input  logic          req_frame_error,
   input  logic          req_line_overrun,
   input  cfg_type       cfg,
   input  ring_stat_type rx_stat,
   input  ring_stat_type tx_stat,
   output ring_cmd_type  rx_cmd,
   output ring_cmd_type  tx_cmd,
   output logic [7:0]    tx_wdata,
   output pend_type      pend,
   output logic [3:0]    error_flags,
   output logic          tx_request
);

   logic [3:0] error_ff, error_in;
   logic       svc_ff, svc_in;

   always_comb begin
      rx_cmd   = '0;
      tx_cmd   = '0;
      pend     = '0;
      error_in = error_ff;
      svc_in   = svc_ff;
      tx_wdata = req_data_in;
      if (cfg.tx_nl_to_cr && req_data_in == CH_NL) begin
         tx_wdata = CH_CR;
      end
      if (accept) begin
         case (req_type)
            REQ_RX_BYTE: begin
               error_in = {1'b0, rx_stat.full, req_line_overrun, req_frame_error};
               if (!rx_stat.full) begin
                  rx_cmd.push = 1'b1;
                  pend.acc    = 1'b1;
               end
            end
            REQ_TX_READY: begin
               if (tx_stat.empty) begin
                  svc_in = 1'b0;
               end else begin
                  tx_cmd.pop = 1'b1;
                  pend.rd_tx = 1'b1;
                  pend.acc   = 1'b1;
               end
            end
            REQ_HOST_WRITE: begin
               if (!tx_stat.full) begin
                  tx_cmd.push = 1'b1;
                  svc_in      = 1'b1;
                  pend.acc    = 1'b1;
               end
            end
            REQ_HOST_READ: begin
               if (rx_stat.empty) begin
                  error_in = error_ff | 4'b1000;
               end else begin
                  rx_cmd.pop = 1'b1;
                  pend.rd_rx = 1'b1;
                  pend.acc   = 1'b1;
               end
            end
            REQ_TX_DISCARD: begin
               tx_cmd.flush = 1'b1;
               pend.acc     = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_ff <= '0;
         svc_ff   <= 1'b0;
      end else begin
         error_ff <= error_in;
         svc_ff   <= svc_in;
      end
   end

   assign error_flags = error_ff;
   assign tx_request  = svc_ff;

endmodule

// File: rtl/core/buffered_uart_ring_fifos.sv
// Pipeline: two register stages (ring read, then result register); an accepted
// item reads its ring in the read stage, then moves on to the result register.
// Throughput: one item per cycle while rsp_stall is low; behind a stalled result
// one more item waits in the read stage before the input stalls.
// Reset clears the ring pointers, error flags, service flag and options;
// the ring memories are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
// buffered_uart_ring_fifos
// UART front end with receive and transmit byte rings, error flags and
// optional CR/newline translation.
// ---------------------------------------------------------------------------
module buffered_uart_ring_fifos
   import bur_pkg::*;
#(
   parameter int RX_DEPTH = RxDepthDefault,
   parameter int TX_DEPTH = TxDepthDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [2:0]               req_type,
   input  logic [7:0]               req_data_in,
   input  logic                     req_frame_error,
   input  logic                     req_line_overrun,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_data_out,
   output logic                     rsp_data_valid,
   output logic                     rsp_accepted,
   output logic [5:0]               rsp_rx_count,
   output logic                     rsp_tx_empty,
   output logic                     rsp_tx_request,
   output logic [3:0]               rsp_error_flags,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic                     csr_data
);

   localparam int RX_PW = $clog2(RX_DEPTH);
   localparam int TX_PW = $clog2(TX_DEPTH);

   cfg_type       cfg_ff, cfg_in;
   ring_cmd_type  rx_cmd, tx_cmd;
   ring_stat_type rx_stat, tx_stat;
   logic [7:0]    rx_rdata, tx_rdata, tx_wdata;
   logic [RX_PW-1:0] rx_cnt;
   logic [TX_PW-1:0] tx_cnt;
   logic [RX_PW+5:0] rx_cnt_wide;
   pend_type      pend;
   logic [3:0]    error_flags;
   logic          tx_request;
   logic          accept;
   logic          p_adv;
   logic          p_valid_ff, p_valid_in;
   pend_type      p_pend_ff;
   logic          o_valid_ff, o_valid_in;
   logic [7:0]    o_data_ff, o_data_in;
   logic          o_dvalid_ff, o_acc_ff;
   logic [5:0]    o_rx_count_ff;
   logic          o_tx_empty_ff, o_tx_request_ff;
   logic [3:0]    o_error_ff;

   // configuration
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TX_NL_TO_CR: cfg_in.tx_nl_to_cr = csr_data;
            CSR_RX_CR_TO_NL: cfg_in.rx_cr_to_nl = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // handshake: the read stage moves on when the result register is free or its result is taken
   assign p_adv     = p_valid_ff && (!o_valid_ff || !rsp_stall);
   assign req_stall = p_valid_ff && !p_adv;
   assign accept    = req_valid && !req_stall;

   bur_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_type         (req_type),
      .req_data_in      (req_data_in),
      .req_frame_error  (req_frame_error),
      .req_line_overrun (req_line_overrun),
      .cfg              (cfg_ff),
      .rx_stat          (rx_stat),
      .tx_stat          (tx_stat),
      .rx_cmd           (rx_cmd),
      .tx_cmd           (tx_cmd),
      .tx_wdata         (tx_wdata),
      .pend             (pend),
      .error_flags      (error_flags),
      .tx_request       (tx_request)
   );

   bur_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
      .clock (clock),
      .reset (reset),
      .cmd   (rx_cmd),
      .wdata (req_data_in),
      .rdata (rx_rdata),
      .stat  (rx_stat),
      .count (rx_cnt)
   );

   bur_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
      .clock (clock),
      .reset (reset),
      .cmd   (tx_cmd),
      .wdata (tx_wdata),
      .rdata (tx_rdata),
      .stat  (tx_stat),
      .count (tx_cnt)
   );

   // read stage
   assign p_valid_in = accept || (p_valid_ff && !p_adv);

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= p_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         p_pend_ff <= pend;
      end
   end

   // result register; ring status is the state left by the item in the read stage
   assign rx_cnt_wide = {6'd0, rx_cnt};
   assign o_valid_in  = p_adv || (o_valid_ff && rsp_stall);

   always_comb begin
      o_data_in = '0;
      if (p_pend_ff.rd_tx) begin
         o_data_in = tx_rdata;
      end else if (p_pend_ff.rd_rx) begin
         o_data_in = rx_rdata;
         if (cfg_ff.rx_cr_to_nl && rx_rdata == CH_CR) begin
            o_data_in = CH_NL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else begin
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (p_adv) begin
         o_data_ff       <= o_data_in;
         o_dvalid_ff     <= p_pend_ff.rd_tx || p_pend_ff.rd_rx;
         o_acc_ff        <= p_pend_ff.acc;
         o_rx_count_ff   <= rx_cnt_wide[5:0];
         o_tx_empty_ff   <= tx_stat.empty && (tx_cnt == '0);
         o_tx_request_ff <= tx_request;
         o_error_ff      <= error_flags;
      end
   end

   assign rsp_valid       = o_valid_ff;
   assign rsp_data_out    = o_data_ff;
   assign rsp_data_valid  = o_dvalid_ff;
   assign rsp_accepted    = o_acc_ff;
   assign rsp_rx_count    = o_rx_count_ff;
   assign rsp_tx_empty    = o_tx_empty_ff;
   assign rsp_tx_request  = o_tx_request_ff;
   assign rsp_error_flags = o_error_ff;

   // checks
   a_ring_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      !(rx_stat.full && rx_stat.empty) && !(tx_stat.full && tx_stat.empty))
      else $error("ring reports full and empty together");

   a_read_stage_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> p_valid_ff && $stable(p_pend_ff))
      else $error("read stage lost its item while stalled");

   a_one_ring_read: assert property (@(posedge clock) disable iff (reset)
      !(pend.rd_rx && pend.rd_tx))
      else $error("both rings read for one item");

   a_data_needs_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data_valid |-> rsp_accepted)
      else $error("byte returned on a failed request");

endmodule
